>>> hw/rtl/ndtk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndtk_pkg
// Shared types and codes for the nearest detection top-K filter.
// ----------------------------------------------------------------------------
package ndtk_pkg;

  typedef enum logic [1:0] {
    CMD_DETECT  = 2'd0,
    CMD_FRAME   = 2'd1,
    CMD_EVAL    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_RUNNING = 2'd0,
    STAT_FAIL    = 2'd1,
    STAT_SUCCESS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_TAIL,
    ST_INS_RD,
    ST_INS_CMP,
    ST_EV_RD,
    ST_EV_OUT,
    ST_STAT
  } state_t;

  // configuration register indexes
  localparam logic [2:0] CFG_TARGET_CLASS   = 3'd0;
  localparam logic [2:0] CFG_MIN_CONFIDENCE = 3'd1;
  localparam logic [2:0] CFG_MAX_DISTANCE   = 3'd2;
  localparam logic [2:0] CFG_MAX_FRAMES     = 3'd3;
  localparam logic [2:0] CFG_MIN_DETECTIONS = 3'd4;
  localparam logic [2:0] CFG_KEEP_LIMIT     = 3'd5;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // one kept detection
  typedef struct packed {
    logic [63:0] payload;
    logic [15:0] confidence;
    logic [15:0] distance;
  } entry_t;

endpackage

>>> hw/rtl/ndtk_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndtk_store
// Kept-entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ndtk_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  ndtk_pkg::entry_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output ndtk_pkg::entry_t rd_data
);
  import ndtk_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/nearest_detection_top_k_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_detection_top_k_filter_top
// Threshold filter and sorted nearest-K list of object detections.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_*): one transaction per command. s_tuser carries the
//    command (detection, frame tick, evaluate, restart); s_tdata carries the
//    detection fields, used by detections only.
//  - Output stream (m_*): evaluate answers with one or more transactions.
//    m_tuser is the status, m_tlast marks the final one of an evaluation.
//  - Config channel (cfg_*): always ready; write only while the block idles.
//  - Command handling: frame tick and restart complete on acceptance, as
//    does a rejected detection. A kept detection runs the insertion walk,
//    which reads one entry of the kept-list memory, compares it and writes
//    one shifted entry back per step. Evaluate reads each reported entry,
//    then loads it into the output register, or loads a single
//    running/failure answer. No new command is taken until one finishes.
//  - The output register decouples the sides: a pending result does not
//    block detections or ticks; a new evaluate waits for the register.
//  - Receiver stall: the evaluate walk holds in place until m_tready frees
//    the output register; nothing is dropped.
//  - Reset: counters and list length clear, registers take their defaults.
//    Memory contents are not cleared; entries beyond the list length are
//    never read.
// ----------------------------------------------------------------------------
module nearest_detection_top_k_filter_top #(
  parameter int KEEP_DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // det_class[7:0], det_confidence[23:8],
                                  // det_distance[39:24], det_payload[103:40]
  input  logic [1:0]   s_tuser,   // cmd[1:0]
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // out_distance[15:0], out_confidence[31:16],
                                  // out_payload[95:32]
  output logic [1:0]   m_tuser,   // status[1:0]
  output logic         m_tlast,
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import ndtk_pkg::*;

  localparam int AW  = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;
  localparam int CW  = $clog2(KEEP_DEPTH + 1);
  localparam int LW  = (CW > 4) ? CW : 4;
  localparam logic [AW-1:0] LAST_ADDR = AW'(KEEP_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(KEEP_DEPTH);

  // configuration registers
  logic [7:0]  target_class;
  logic [15:0] min_confidence;
  logic [15:0] max_distance;
  logic [15:0] max_frames;
  logic [15:0] min_detections;
  logic [3:0]  keep_limit;

  // run state
  logic [CW-1:0] kept_count;
  logic [15:0]   accepted_count;
  logic [15:0]   frame_count;

  state_t        state, state_next;
  entry_t        new_entry;      // detection being inserted
  logic [AW-1:0] pos, pos_next;  // hole being filled by the insert walk
  logic [AW-1:0] ev_idx, ev_idx_next;
  logic [AW-1:0] ev_last;
  status_t       stat_hold;      // running/failure verdict awaiting output

  // memory ports
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;

  // output register
  logic          out_free, out_load;
  status_t       out_status, out_status_next;
  entry_t        out_entry, out_entry_next;
  logic          out_last, out_last_next;

  // input decode
  cmd_t          cmd;
  entry_t        in_entry;
  logic [7:0]    in_class;
  logic          s_fire, det_match;
  logic [15:0]   need;
  logic [LW-1:0] lim;
  logic [LW-1:0] n_eff;

  assign cmd       = cmd_t'(s_tuser);
  assign in_class  = s_tdata[7:0];
  assign in_entry  = '{payload: s_tdata[103:40], confidence: s_tdata[23:8],
                       distance: s_tdata[39:24]};
  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign det_match = (in_class == target_class) &&
                     (in_entry.confidence >= min_confidence) &&
                     (in_entry.distance <= max_distance);
  assign need      = (min_detections == '0) ? 16'd1 : min_detections;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // effective report count: keep_limit clamped to 1..KEEP_DEPTH, then to list
  always_comb begin
    lim = LW'(keep_limit);
    if (lim == '0) begin
      lim = LW'(1);
    end
    if (lim > LW'(KEEP_DEPTH)) begin
      lim = LW'(KEEP_DEPTH);
    end
    n_eff = (LW'(kept_count) < lim) ? LW'(kept_count) : lim;
  end

  ndtk_store #(
    .DEPTH (KEEP_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // FSM state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, memory controls, output load
  always_comb begin
    state_next      = state;
    pos_next        = pos;
    ev_idx_next     = ev_idx;
    wr_en           = 1'b0;
    wr_addr         = pos;
    wr_data         = new_entry;
    rd_en           = 1'b0;
    rd_addr         = pos - AW'(1);
    out_load        = 1'b0;
    out_status_next = out_status;
    out_entry_next  = out_entry;
    out_last_next   = out_last;
    case (state)
      ST_IDLE: begin
        if (s_fire) begin
          case (cmd)
            CMD_DETECT: begin
              if (det_match) begin
                if (kept_count == FULL_CNT) begin
                  // full list: check the farthest entry first
                  rd_en      = 1'b1;
                  rd_addr    = LAST_ADDR;
                  pos_next   = LAST_ADDR;
                  state_next = ST_INS_TAIL;
                end else begin
                  pos_next   = kept_count[AW-1:0];
                  state_next = ST_INS_RD;
                end
              end
            end
            CMD_EVAL: begin
              ev_idx_next = '0;
              if (frame_count >= max_frames) begin
                state_next = ST_STAT;
              end else if (accepted_count < need || kept_count == '0) begin
                state_next = ST_STAT;
              end else begin
                state_next = ST_EV_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INS_TAIL: begin
        // ties with the farthest entry are dropped
        if (rd_data.distance > new_entry.distance) begin
          state_next = ST_INS_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_INS_RD: begin
        if (pos == '0) begin
          wr_en      = 1'b1;
          state_next = ST_IDLE;
        end else begin
          rd_en      = 1'b1;
          state_next = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        wr_en = 1'b1;
        if (rd_data.distance > new_entry.distance) begin
          // shift the farther entry one slot back
          wr_data    = rd_data;
          pos_next   = pos - AW'(1);
          state_next = ST_INS_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EV_RD: begin
        rd_en      = 1'b1;
        rd_addr    = ev_idx;
        state_next = ST_EV_OUT;
      end
      ST_EV_OUT: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_next = STAT_SUCCESS;
          out_entry_next  = rd_data;
          out_last_next   = (ev_idx == ev_last);
          if (ev_idx == ev_last) begin
            state_next = ST_IDLE;
          end else begin
            ev_idx_next = ev_idx + AW'(1);
            state_next  = ST_EV_RD;
          end
        end
      end
      ST_STAT: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_next = stat_hold;
          out_entry_next  = '0;
          out_last_next   = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      target_class   <= '0;
      min_confidence <= '0;
      max_distance   <= 16'hFFFF;
      max_frames     <= 16'hFFFF;
      min_detections <= 16'd1;
      keep_limit     <= 4'd8;
      kept_count     <= '0;
      accepted_count <= '0;
      frame_count    <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TARGET_CLASS:   target_class   <= cfg_data[7:0];
          CFG_MIN_CONFIDENCE: min_confidence <= cfg_data;
          CFG_MAX_DISTANCE:   max_distance   <= cfg_data;
          CFG_MAX_FRAMES:     max_frames     <= cfg_data;
          CFG_MIN_DETECTIONS: min_detections <= cfg_data;
          CFG_KEEP_LIMIT:     keep_limit     <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (s_fire) begin
        case (cmd)
          CMD_DETECT: begin
            if (det_match) begin
              if (accepted_count != CNT_MAX) begin
                accepted_count <= accepted_count + 16'd1;
              end
              if (kept_count != FULL_CNT) begin
                kept_count <= kept_count + CW'(1);
              end
            end
          end
          CMD_FRAME: begin
            if (frame_count != CNT_MAX) begin
              frame_count <= frame_count + 16'd1;
            end
          end
          CMD_RESTART: begin
            kept_count     <= '0;
            accepted_count <= '0;
            frame_count    <= '0;
          end
          default: ;
        endcase
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    pos    <= pos_next;
    ev_idx <= ev_idx_next;
    if (s_fire) begin
      new_entry <= in_entry;
      ev_last   <= AW'(n_eff - LW'(1));
      stat_hold <= (frame_count >= max_frames) ? STAT_FAIL : STAT_RUNNING;
    end
    if (out_load) begin
      out_status <= out_status_next;
      out_entry  <= out_entry_next;
      out_last   <= out_last_next;
    end
  end

  assign m_tdata = {out_entry.payload, out_entry.confidence, out_entry.distance};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= FULL_CNT)
    else $error("kept_count above depth");

  a_accept_covers_list: assert property (@(posedge clk) disable iff (rst)
    CW'(kept_count) <= accepted_count[CW-1:0] || accepted_count >= 16'(KEEP_DEPTH))
    else $error("list longer than accepted detections");

  a_cmp_not_head: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS_CMP) |-> (pos != '0))
    else $error("compare step at list head");

  a_write_only_insert: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_INS_RD || state == ST_INS_CMP))
    else $error("memory write outside insert");

  a_eval_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EV_RD) |-> (CW'(ev_idx) < kept_count))
    else $error("evaluate reads past list end");

endmodule
